// File: rtl/core/aee_pkg.sv
package aee_pkg;

    // field widths and layout of the stream words
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DT_W       = 24;
    localparam int unsigned DT_FRAC    = 24;
    localparam int unsigned REF_FRAC   = 24;
    localparam int unsigned IN_W       = 3 * WORD_W + DT_W;
    localparam int unsigned OUT_W      = 3 * WORD_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned PIPE_DEPTH = 6;

    typedef logic signed [WORD_W-1:0] t_q;
    typedef logic [DT_W-1:0]          t_dt;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A = 3'd0,
        REG_B = 3'd1,
        REG_C = 3'd2,
        REG_D = 3'd3,
        REG_E = 3'd4,
        REG_F = 3'd5
    } t_reg_idx;

    // coefficient reset values, given with REF_FRAC fraction bits
    localparam t_q RST_A = 32'sd15938355;
    localparam t_q RST_B = 32'sd11744051;
    localparam t_q RST_C = 32'sd10066330;
    localparam t_q RST_D = 32'sd58720256;
    localparam t_q RST_E = 32'sd4194304;
    localparam t_q RST_F = 32'sd1677722;

    localparam t_q Q_MAX = 32'sh7fffffff;
    localparam t_q Q_MIN = 32'sh80000000;

    // reciprocal of three, exact for any 32-bit magnitude with a shift of 33
    localparam logic [31:0] DIV3_RECIP = 32'haaaaaaab;
    localparam int unsigned DIV3_SHIFT = 33;

    // clamp a wide signed value to the 32-bit range
    function automatic t_q f_sat(input logic signed [65:0] v);
        t_q r;
        if (v > 66'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 66'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_q f_qadd(input t_q a, input t_q b);
        return f_sat(66'(a) + 66'(b));
    endfunction

    function automatic t_q f_qsub(input t_q a, input t_q b);
        return f_sat(66'(a) - 66'(b));
    endfunction

    // exact product, round half up at bit sh (floor of p + half), saturate
    function automatic t_q f_qmul(input t_q a, input t_q b, input int unsigned sh);
        logic signed [64:0] p;
        logic signed [64:0] q;
        p = 65'(a) * 65'(b);
        q = p + (65'sd1 <<< (sh - 1));
        return f_sat(66'(q >>> sh));
    endfunction

    // signed divide by three, truncating toward zero
    function automatic t_q f_div3(input t_q v);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] quo;
        mag  = v[WORD_W-1] ? 32'(-v) : 32'(v);
        prod = 64'(mag) * 64'(DIV3_RECIP);
        quo  = 32'(prod >> DIV3_SHIFT);
        return v[WORD_W-1] ? -$signed(quo) : $signed(quo);
    endfunction

    // move a reset constant to another number of fraction bits
    function automatic t_q f_rescale(input t_q v, input int unsigned fb);
        t_q r;
        if (fb >= REF_FRAC) begin
            r = v <<< (fb - REF_FRAC);
        end else begin
            r = v >>> (REF_FRAC - fb);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/aizawa_attractor_euler_step.sv
// Aizawa attractor, one forward-Euler step per word.
//
// input stream: one word holds a point (x, y, z) and the step dt; the point
// comes back on the output stream moved by one Euler step, every value
// signed fixed point with FRAC_BITS fraction bits, dt unsigned Q0.24, all
// products and sums clamped to the 32-bit range.
// coefficients a to f are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no word is in flight,
// which the block does not enforce; indexes six and seven are ignored.
// six register stages take an accepted input word to o_m_axis_tvalid;
// the deepest: a 32x32 multiply, rounding, clamping, then a clamped add.
// throughput: one word per cycle unless the output stalls; each stage
// holds a valid bit and loads whenever it is empty or the stage behind
// it moves, so bubbles close up.
// when the receiver drops i_m_axis_tready the last stage holds its word,
// the stages before it keep filling, and o_s_axis_tready falls only once
// all six stages are full.
// reset: the pipeline empties and the coefficients return to default values.
module aizawa_attractor_euler_step #(
    parameter int unsigned FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input word
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, pos_z, time_step
    input  logic [aee_pkg::IN_W-1:0]            i_s_axis_tdata,
    // output word
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // next_x, next_y, next_z
    output logic [aee_pkg::OUT_W-1:0]           o_m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [aee_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [aee_pkg::WORD_W-1:0]          i_cfg_data
);
    import aee_pkg::*;

    localparam t_q ONE = t_q'(64'sd1 <<< FRAC_BITS);

    // coefficient registers
    t_q r_coef_a, r_coef_b, r_coef_c, r_coef_d, r_coef_e, r_coef_f;

    // stage valid bits and load enables
    logic [PIPE_DEPTH:1]   r_vld;
    logic [PIPE_DEPTH+1:1] ld;

    // unpacked input word
    t_q  in_x, in_y, in_z;
    t_dt in_dt;

    // stage 1
    t_q  r_s1_x, r_s1_y, r_s1_z, r_s1_zb, r_s1_x2, r_s1_y2, r_s1_ez;
    t_q  r_s1_zz, r_s1_az, r_s1_fz, r_s1_dx, r_s1_dy;
    t_dt r_s1_dt;
    // stage 2
    t_q  r_s2_x, r_s2_y, r_s2_z, r_s2_dx, r_s2_dy, r_s2_r2, r_s2_ez1;
    t_q  r_s2_z3, r_s2_x3, r_s2_fz, r_s2_dza;
    t_dt r_s2_dt;
    // stage 3
    t_q  r_s3_nx, r_s3_ny, r_s3_z, r_s3_dza, r_s3_z3d, r_s3_rez, r_s3_fzx3;
    t_dt r_s3_dt;
    // stage 4
    t_q  r_s4_nx, r_s4_ny, r_s4_z, r_s4_t, r_s4_fzx3;
    t_dt r_s4_dt;
    // stage 5
    t_q  r_s5_nx, r_s5_ny, r_s5_z, r_s5_dz;
    t_dt r_s5_dt;
    // stage 6, output register
    t_q  r_s6_nx, r_s6_ny, r_s6_nz;

    assign in_x  = i_s_axis_tdata[WORD_W-1:0];
    assign in_y  = i_s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_z  = i_s_axis_tdata[3*WORD_W-1:2*WORD_W];
    assign in_dt = i_s_axis_tdata[3*WORD_W+DT_W-1:3*WORD_W];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= f_rescale(RST_A, FRAC_BITS);
            r_coef_b <= f_rescale(RST_B, FRAC_BITS);
            r_coef_c <= f_rescale(RST_C, FRAC_BITS);
            r_coef_d <= f_rescale(RST_D, FRAC_BITS);
            r_coef_e <= f_rescale(RST_E, FRAC_BITS);
            r_coef_f <= f_rescale(RST_F, FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_A:   r_coef_a <= i_cfg_data;
                REG_B:   r_coef_b <= i_cfg_data;
                REG_C:   r_coef_c <= i_cfg_data;
                REG_D:   r_coef_d <= i_cfg_data;
                REG_E:   r_coef_e <= i_cfg_data;
                REG_F:   r_coef_f <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    always_comb begin
        ld[PIPE_DEPTH+1] = i_m_axis_tready;
        for (int k = PIPE_DEPTH; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_s_axis_tready = ld[1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: first-level products and z - b
    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s1_x  <= in_x;
            r_s1_y  <= in_y;
            r_s1_z  <= in_z;
            r_s1_dt <= in_dt;
            r_s1_zb <= f_qsub(in_z, r_coef_b);
            r_s1_x2 <= f_qmul(in_x, in_x, FRAC_BITS);
            r_s1_y2 <= f_qmul(in_y, in_y, FRAC_BITS);
            r_s1_ez <= f_qmul(r_coef_e, in_z, FRAC_BITS);
            r_s1_zz <= f_qmul(in_z, in_z, FRAC_BITS);
            r_s1_az <= f_qmul(r_coef_a, in_z, FRAC_BITS);
            r_s1_fz <= f_qmul(r_coef_f, in_z, FRAC_BITS);
            r_s1_dx <= f_qmul(r_coef_d, in_x, FRAC_BITS);
            r_s1_dy <= f_qmul(r_coef_d, in_y, FRAC_BITS);
        end
    end

    // stage 2: dx, dy, cubes, squared radius, 1 + e z and c + a z
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_z   <= r_s1_z;
            r_s2_dt  <= r_s1_dt;
            r_s2_dx  <= f_qsub(f_qmul(r_s1_zb, r_s1_x, FRAC_BITS), r_s1_dy);
            r_s2_dy  <= f_qadd(r_s1_dx, f_qmul(r_s1_zb, r_s1_y, FRAC_BITS));
            r_s2_r2  <= f_qadd(r_s1_x2, r_s1_y2);
            r_s2_ez1 <= f_qadd(ONE, r_s1_ez);
            r_s2_z3  <= f_qmul(r_s1_zz, r_s1_z, FRAC_BITS);
            r_s2_x3  <= f_qmul(r_s1_x2, r_s1_x, FRAC_BITS);
            r_s2_fz  <= r_s1_fz;
            r_s2_dza <= f_qadd(r_coef_c, r_s1_az);
        end
    end

    // stage 3: x and y updates, z^3/3, radial and f z x^3 terms
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s3_nx   <= f_qadd(r_s2_x,
                                f_qmul(r_s2_dx, t_q'({1'b0, r_s2_dt}), DT_FRAC));
            r_s3_ny   <= f_qadd(r_s2_y,
                                f_qmul(r_s2_dy, t_q'({1'b0, r_s2_dt}), DT_FRAC));
            r_s3_z    <= r_s2_z;
            r_s3_dt   <= r_s2_dt;
            r_s3_dza  <= r_s2_dza;
            r_s3_z3d  <= f_div3(r_s2_z3);
            r_s3_rez  <= f_qmul(r_s2_r2, r_s2_ez1, FRAC_BITS);
            r_s3_fzx3 <= f_qmul(r_s2_fz, r_s2_x3, FRAC_BITS);
        end
    end

    // stage 4: subtract the cube and radial terms in order
    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s4_nx   <= r_s3_nx;
            r_s4_ny   <= r_s3_ny;
            r_s4_z    <= r_s3_z;
            r_s4_dt   <= r_s3_dt;
            r_s4_t    <= f_qsub(f_qsub(r_s3_dza, r_s3_z3d), r_s3_rez);
            r_s4_fzx3 <= r_s3_fzx3;
        end
    end

    // stage 5: finish dz
    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_s5_nx <= r_s4_nx;
            r_s5_ny <= r_s4_ny;
            r_s5_z  <= r_s4_z;
            r_s5_dt <= r_s4_dt;
            r_s5_dz <= f_qadd(r_s4_t, r_s4_fzx3);
        end
    end

    // stage 6: z update into the output register
    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_s6_nx <= r_s5_nx;
            r_s6_ny <= r_s5_ny;
            r_s6_nz <= f_qadd(r_s5_z,
                              f_qmul(r_s5_dz, t_q'({1'b0, r_s5_dt}), DT_FRAC));
        end
    end

    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH];
    assign o_m_axis_tdata  = {r_s6_nz, r_s6_ny, r_s6_nx};

endmodule

// File: rtl/core/aee_chk.sv
module aee_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [aee_pkg::OUT_W-1:0]     o_m_axis_tdata
);
    import aee_pkg::*;

    logic in_acc, out_acc;
    logic [3:0] r_cnt;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(in_acc) - 4'(out_acc);
        end
    end

    // pipeline empty after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // input only backs up when the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while output not stalled");

    // never more words in flight than stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // no output word without an accepted input word
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_cnt != 4'd0))
        else $error("output word with nothing accepted");

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind aizawa_attractor_euler_step aee_chk u_aee_chk (.*);
